@@ hw/rtl/v3alu_pkg.sv @@
package v3alu_pkg;

  // Opcodes carried by the cmd field
  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_SCALE = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_DOT   = 3'd4,
    CMD_CROSS = 3'd5,
    CMD_NORM  = 3'd6,
    CMD_MAG   = 3'd7
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SAT     = 2'd1,
    ST_DIVZERO = 2'd2
  } status_t;

  // One square-root step per result bit of a 64-bit radicand
  localparam int SQ_STEPS = 32;

endpackage

@@ hw/rtl/vector3_alu.sv @@
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    cmd, ax, ay, az, bx, by, bz, scale
// result    out        out_valid / out_stall  rx, ry, rz, rscalar, status
//
// One transaction enters per cycle unless in_stall is high; results leave in the
// order of their input transactions, through the 32-stage square-root pipeline
// followed by the 33 + FRAC_BITS stage divider.
// rst is synchronous and clears only the valid bits of every stage.
// A stalled result holds in the output register; the pipeline behind it keeps
// moving while the stage feeding the output register is empty.
module vector3_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] az,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  logic signed [31:0] bz,
  input  logic signed [31:0] scale,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] rx,
  output logic signed [31:0] ry,
  output logic signed [31:0] rz,
  output logic signed [31:0] rscalar,
  output logic [1:0]         status
);

  // Width of the rounded dividend and of the quotient: |a| << FRAC_BITS plus den/2
  localparam int NW = 33 + FRAC_BITS;
  localparam int SQN = v3alu_pkg::SQ_STEPS;

  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] MAXV = 66'sd2147483647;
  localparam logic signed [65:0] MINV = -66'sd2147483648;
  localparam logic [NW-1:0] QMAX = NW'(64'h7FFFFFFF);
  localparam logic [NW-1:0] QMIN = NW'(64'h80000000);

  // Everything an item carries down the pipeline besides the arithmetic state
  typedef struct packed {
    v3alu_pkg::cmd_t  cmd;
    logic [2:0][31:0] a;
    logic [31:0]      s;
    logic [2:0][31:0] res;
    logic [31:0]      rs;
    logic             sat;
    logic             dz;
    logic             pass;
  } carry_t;

  function automatic logic [32:0] sat66(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > MAXV) begin
      r = {1'b1, 32'h7FFFFFFF};
    end else if (v < MINV) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Round to nearest, ties toward +infinity, then saturate
  function automatic logic [32:0] round66(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v + HALF) >>> FRAC_BITS;
    return sat66(t);
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [32:0] pack_q(input logic neg, input logic [NW-1:0] q);
    logic [32:0] r;
    logic [NW-1:0] nq;
    nq = NW'(0) - q;
    if (!neg) begin
      r = (q > QMAX) ? {1'b1, 32'h7FFFFFFF} : {1'b0, q[31:0]};
    end else begin
      r = (q > QMIN) ? {1'b1, 32'h80000000} : {1'b0, nq[31:0]};
    end
    return r;
  endfunction

  // Pipeline advance: the output register takes a new item when empty or taken;
  // the stages behind it may also move when the last divider stage is empty.
  logic adv;
  logic out_load;
  logic [NW:0] dv_v;

  assign out_load = !out_valid || !out_stall;
  assign adv      = out_load || !dv_v[NW];
  assign in_stall = !adv;

  // ---------------- stage A: input register ----------------
  logic             a_v;
  v3alu_pkg::cmd_t  a_cmd;
  logic [2:0][31:0] a_a;
  logic [2:0][31:0] a_b;
  logic [31:0]      a_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= in_valid;
    end
    if (adv) begin
      a_cmd <= v3alu_pkg::cmd_t'(cmd);
      a_a   <= {az, ay, ax};
      a_b   <= {bz, by, bx};
      a_s   <= scale;
    end
  end

  // ---------------- stage B: operand select, multiply, add/sub ----------------
  logic [2:0][31:0] x0, y0, x1, y1;
  carry_t           b_c_next;
  logic             b_v;
  carry_t           b_c;
  logic signed [63:0] b_p0 [3];
  logic signed [63:0] b_p1 [3];

  always_comb begin
    logic signed [65:0] sum;
    logic [32:0] sv;
    b_c_next      = '0;
    b_c_next.cmd  = a_cmd;
    b_c_next.a    = a_a;
    b_c_next.s    = a_s;
    x0 = '0;
    y0 = '0;
    x1 = '0;
    y1 = '0;
    sum = '0;
    sv  = '0;
    case (a_cmd)
      v3alu_pkg::CMD_ADD, v3alu_pkg::CMD_SUB: begin
        b_c_next.pass = 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (a_cmd == v3alu_pkg::CMD_ADD) begin
            sum = {{34{a_a[i][31]}}, a_a[i]} + {{34{a_b[i][31]}}, a_b[i]};
          end else begin
            sum = {{34{a_a[i][31]}}, a_a[i]} - {{34{a_b[i][31]}}, a_b[i]};
          end
          sv = sat66(sum);
          b_c_next.res[i] = sv[31:0];
          b_c_next.sat = b_c_next.sat | sv[32];
        end
      end
      v3alu_pkg::CMD_SCALE: begin
        x0 = a_a;
        y0 = {a_s, a_s, a_s};
      end
      v3alu_pkg::CMD_DOT: begin
        x0 = a_a;
        y0 = a_b;
      end
      v3alu_pkg::CMD_CROSS: begin
        // lane i: a[j]*b[k] - a[k]*b[j], j = i+1, k = i+2 (mod 3)
        x0 = {a_a[0], a_a[2], a_a[1]};
        y0 = {a_b[1], a_b[0], a_b[2]};
        x1 = {a_a[1], a_a[0], a_a[2]};
        y1 = {a_b[0], a_b[2], a_b[1]};
      end
      v3alu_pkg::CMD_NORM, v3alu_pkg::CMD_MAG: begin
        x0 = a_a;
        y0 = a_a;
      end
      default: begin
        x0 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= a_v;
    end
    if (adv) begin
      b_c <= b_c_next;
      for (int i = 0; i < 3; i++) begin
        b_p0[i] <= $signed(x0[i]) * $signed(y0[i]);
        b_p1[i] <= $signed(x1[i]) * $signed(y1[i]);
      end
    end
  end

  // ---------------- stage C: difference and three-way sum ----------------
  logic               c_v;
  carry_t             c_c;
  logic signed [65:0] c_acc [3];
  logic signed [65:0] c_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= b_v;
    end
    if (adv) begin
      c_c <= b_c;
      for (int i = 0; i < 3; i++) begin
        c_acc[i] <= {{2{b_p0[i][63]}}, b_p0[i]} - {{2{b_p1[i][63]}}, b_p1[i]};
      end
      c_sum <= {{2{b_p0[0][63]}}, b_p0[0]} + {{2{b_p0[1][63]}}, b_p0[1]}
             + {{2{b_p0[2][63]}}, b_p0[2]};
    end
  end

  // ---------------- stage D: round products, seed square root ----------------
  logic         sq_v [0:SQN];
  carry_t       sq_c [0:SQN];
  logic [63:0]  sq_x [0:SQN];
  logic [63:0]  sq_r [0:SQN];
  carry_t       d_c_next;

  always_comb begin
    logic [32:0] rv;
    d_c_next = c_c;
    rv = '0;
    case (c_c.cmd)
      v3alu_pkg::CMD_SCALE, v3alu_pkg::CMD_CROSS: begin
        d_c_next.pass = 1'b1;
        for (int i = 0; i < 3; i++) begin
          rv = round66(c_acc[i]);
          d_c_next.res[i] = rv[31:0];
          d_c_next.sat = d_c_next.sat | rv[32];
        end
      end
      v3alu_pkg::CMD_DOT: begin
        d_c_next.pass = 1'b1;
        rv = round66(c_sum);
        d_c_next.rs  = rv[31:0];
        d_c_next.sat = rv[32];
      end
      default: begin
        d_c_next.pass = c_c.pass;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= c_v;
    end
    if (adv) begin
      sq_c[0] <= d_c_next;
      sq_x[0] <= c_sum[63:0];
      sq_r[0] <= '0;
    end
  end

  // ---------------- square root: one result bit per stage ----------------
  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    localparam logic [63:0] BITK = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        take;

    always_comb begin
      trial = sq_r[k] + BITK;
      take  = sq_x[k] >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
      if (adv) begin
        sq_c[k+1] <= sq_c[k];
        sq_x[k+1] <= take ? (sq_x[k] - trial) : sq_x[k];
        sq_r[k+1] <= take ? ((sq_r[k] >> 1) + BITK) : (sq_r[k] >> 1);
      end
    end
  end

  // ---------------- stage E: magnitude, special cases, divider setup ----------------
  carry_t       dv_c   [0:NW];
  logic [31:0]  dv_den [0:NW];
  logic [NW-1:0] dv_n  [0:NW][3];
  logic [NW-1:0] dv_q  [0:NW][3];
  logic [31:0]  dv_rem [0:NW][3];
  logic         dv_sgn [0:NW][3];

  carry_t       e_c_next;
  logic [31:0]  e_den;
  logic [NW-1:0] e_n [3];
  logic         e_sgn [3];

  always_comb begin
    logic [31:0] m;
    m = sq_r[SQN][31:0];
    e_c_next = sq_c[SQN];
    e_den = 32'd1;
    for (int i = 0; i < 3; i++) begin
      e_sgn[i] = 1'b0;
    end
    case (sq_c[SQN].cmd)
      v3alu_pkg::CMD_MAG: begin
        e_c_next.pass = 1'b1;
        e_c_next.sat  = m[31];
        e_c_next.rs   = m[31] ? 32'h7FFFFFFF : m;
      end
      v3alu_pkg::CMD_NORM: begin
        if (m == 32'd0) begin
          // zero vector: return A unchanged
          e_c_next.pass = 1'b1;
          e_c_next.res  = sq_c[SQN].a;
        end else begin
          e_den = m;
          for (int i = 0; i < 3; i++) begin
            e_sgn[i] = sq_c[SQN].a[i][31];
          end
        end
      end
      v3alu_pkg::CMD_DIV: begin
        if (sq_c[SQN].s == 32'd0) begin
          e_c_next.pass = 1'b1;
          e_c_next.dz   = 1'b1;
        end else begin
          e_den = abs32(sq_c[SQN].s);
          for (int i = 0; i < 3; i++) begin
            e_sgn[i] = sq_c[SQN].a[i][31] ^ sq_c[SQN].s[31];
          end
        end
      end
      default: begin
        e_den = 32'd1;
      end
    endcase
    // Round half away from zero: divide |a| << FRAC_BITS plus den/2
    for (int i = 0; i < 3; i++) begin
      e_n[i] = (NW'(abs32(sq_c[SQN].a[i])) << FRAC_BITS) + NW'(e_den >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[SQN];
    end
    if (adv) begin
      dv_c[0]   <= e_c_next;
      dv_den[0] <= e_den;
      for (int i = 0; i < 3; i++) begin
        dv_n[0][i]   <= e_n[i];
        dv_q[0][i]   <= '0;
        dv_rem[0][i] <= '0;
        dv_sgn[0][i] <= e_sgn[i];
      end
    end
  end

  // ---------------- restoring divider: one quotient bit per stage, three lanes ----------------
  for (genvar t = 0; t < NW; t++) begin : g_div
    logic [32:0] trial [3];
    logic        ge    [3];
    logic [31:0] rem_n [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {dv_rem[t][i], dv_n[t][i][NW-1]};
        ge[i]    = trial[i] >= {1'b0, dv_den[t]};
        rem_n[i] = ge[i] ? 32'(trial[i] - {1'b0, dv_den[t]}) : trial[i][31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[t+1] <= 1'b0;
      end else if (adv) begin
        dv_v[t+1] <= dv_v[t];
      end
      if (adv) begin
        dv_c[t+1]   <= dv_c[t];
        dv_den[t+1] <= dv_den[t];
        for (int i = 0; i < 3; i++) begin
          dv_n[t+1][i]   <= dv_n[t][i] << 1;
          dv_q[t+1][i]   <= {dv_q[t][i][NW-2:0], ge[i]};
          dv_rem[t+1][i] <= rem_n[i];
          dv_sgn[t+1][i] <= dv_sgn[t][i];
        end
      end
    end
  end

  // ---------------- output register: sign, saturate, status ----------------
  logic [2:0][31:0] f_res;
  logic [31:0]      f_rs;
  logic [1:0]       f_status;

  always_comb begin
    logic [32:0] pv;
    logic        sat;
    pv    = '0;
    sat   = dv_c[NW].sat;
    f_res = dv_c[NW].res;
    f_rs  = dv_c[NW].rs;
    if (!dv_c[NW].pass) begin
      for (int i = 0; i < 3; i++) begin
        pv = pack_q(dv_sgn[NW][i], dv_q[NW][i]);
        f_res[i] = pv[31:0];
        sat = sat | pv[32];
      end
    end
    if (dv_c[NW].dz) begin
      f_status = v3alu_pkg::ST_DIVZERO;
    end else if (sat) begin
      f_status = v3alu_pkg::ST_SAT;
    end else begin
      f_status = v3alu_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= dv_v[NW];
    end
    if (out_load) begin
      rx      <= f_res[0];
      ry      <= f_res[1];
      rz      <= f_res[2];
      rscalar <= f_rs;
      status  <= f_status;
    end
  end

  // ---------------- assertions ----------------
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output register can move");

  a_divzero_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == v3alu_pkg::ST_DIVZERO) |->
      (rx == 32'sd0 && ry == 32'sd0 && rz == 32'sd0 && rscalar == 32'sd0))
    else $error("divide by zero result is not cleared");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

@@ tb/sv/vector3_alu_tb.sv @@
module vector3_alu_tb;

  localparam int FRAC_BITS  = 16;
  localparam int LATENCY    = 71 + FRAC_BITS;
  localparam int N_RANDOM   = 1630;
  localparam int WATCHDOG   = 20000;
  localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] MAX_NEG = 32'h8000_0000;

  // One result as it leaves the block
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] s;
    logic [1:0]  st;
  } vec_result_t;

  // One row of the directed table; has_exp marks rows with a typed-in answer
  typedef struct {
    v3alu_pkg::cmd_t op;
    logic [31:0] a [3];
    logic [31:0] b [3];
    logic [31:0] k;
    bit          has_exp;
    vec_result_t exp;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] cmd = '0;
  logic signed [31:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0, scale = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] rx, ry, rz, rscalar;
  logic [1:0] status;

  vector3_alu #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk, .rst, .in_valid, .in_stall, .cmd, .ax, .ay, .az, .bx, .by, .bz, .scale,
    .out_valid, .out_stall, .rx, .ry, .rz, .rscalar, .status
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Results still owed by the block, oldest first
  vec_result_t pending_results [$];
  int mismatches = 0;
  int n_sent = 0;
  int n_recv = 0;
  int idle_cycles = 0;
  int op_seen [8];
  bit sat_seen = 0, dz_seen = 0;
  bit send_done = 0;
  bit quiet_phase = 0;   // no idling on either side
  bit hold_req = 0;      // ask receiver for a long stall
  bit timed_out = 0;

  // ---------------------------------------------------------------------------
  // Predictor: exact integer arithmetic at the block's widths
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] clamp_signed(logic signed [65:0] v, inout bit sat);
    if (v > $signed({34'd0, MAX_POS})) begin
      sat = 1;
      return MAX_POS;
    end
    if (v < -$signed(66'sh8000_0000)) begin
      sat = 1;
      return MAX_NEG;
    end
    return v[31:0];
  endfunction

  // Apply sign to a magnitude and saturate
  function automatic logic [31:0] pack_mag(bit neg, logic [63:0] q, inout bit sat);
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) begin
        sat = 1;
        return MAX_POS;
      end
      return q[31:0];
    end
    if (q > 64'h8000_0000) begin
      sat = 1;
      return MAX_NEG;
    end
    return -q[31:0];
  endfunction

  // Round a signed sum of exact products: nearest, ties toward +inf
  function automatic logic [31:0] round_products(logic signed [66:0] acc, inout bit sat);
    logic signed [66:0] q;
    q = (acc + (67'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return clamp_signed(q[65:0], sat);
  endfunction

  // Component divided by a positive magnitude, nearest with ties away from zero
  function automatic logic [31:0] div_nearest(logic [31:0] a, bit den_neg, logic [63:0] den,
                                              inout bit sat);
    logic [31:0] mag_a;
    logic [63:0] num;
    mag_a = a[31] ? -a : a;
    num = {32'd0, mag_a} << FRAC_BITS;
    return pack_mag(a[31] != den_neg, (num + den / 2) / den, sat);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] length_of(logic [31:0] a [3]);
    logic [63:0] sum;
    logic [31:0] m;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m = a[i][31] ? -a[i] : a[i];
      sum += {32'd0, m} * {32'd0, m};
    end
    return floor_sqrt(sum);
  endfunction

  function automatic vec_result_t predict_vec_op(v3alu_pkg::cmd_t op, logic [31:0] a [3],
                                                 logic [31:0] b [3], logic [31:0] k);
    vec_result_t r;
    logic [31:0] v [3];
    logic signed [66:0] acc;
    logic signed [65:0] sum;
    logic [63:0] m;
    bit sat;
    int j, l;
    r = '0;
    sat = 0;
    v = '{default: '0};
    case (op)
      v3alu_pkg::CMD_ADD, v3alu_pkg::CMD_SUB: begin
        for (int i = 0; i < 3; i++) begin
          if (op == v3alu_pkg::CMD_ADD)
            sum = 66'($signed(a[i])) + 66'($signed(b[i]));
          else
            sum = 66'($signed(a[i])) - 66'($signed(b[i]));
          v[i] = clamp_signed(sum, sat);
        end
      end
      v3alu_pkg::CMD_SCALE: begin
        for (int i = 0; i < 3; i++)
          v[i] = round_products(67'($signed(a[i]) * $signed(k)), sat);
      end
      v3alu_pkg::CMD_DIV: begin
        if (k == 0) r.st = v3alu_pkg::ST_DIVZERO;
        else for (int i = 0; i < 3; i++)
          v[i] = div_nearest(a[i], k[31], {32'd0, k[31] ? -k : k}, sat);
      end
      v3alu_pkg::CMD_DOT: begin
        acc = 0;
        for (int i = 0; i < 3; i++) acc += 67'($signed(a[i]) * $signed(b[i]));
        r.s = round_products(acc, sat);
      end
      v3alu_pkg::CMD_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          l = (i + 2) % 3;
          acc = 67'($signed(a[j]) * $signed(b[l])) - 67'($signed(a[l]) * $signed(b[j]));
          v[i] = round_products(acc, sat);
        end
      end
      v3alu_pkg::CMD_NORM: begin
        m = length_of(a);
        if (m == 0) v = a;
        else for (int i = 0; i < 3; i++) v[i] = div_nearest(a[i], 0, m, sat);
      end
      default: r.s = pack_mag(0, length_of(a), sat);
    endcase
    r.x = v[0];
    r.y = v[1];
    r.z = v[2];
    if (r.st == v3alu_pkg::ST_OK && sat) r.st = v3alu_pkg::ST_SAT;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  localparam logic [31:0] ONE = 32'h0001_0000;
  vec_row_t directed [$];

  function automatic vec_result_t vres(logic [31:0] x, y, z, s, logic [1:0] st);
    vec_result_t r;
    r.x = x; r.y = y; r.z = z; r.s = s; r.st = st;
    return r;
  endfunction

  task automatic add_row(v3alu_pkg::cmd_t op, logic [31:0] a0, a1, a2, b0, b1, b2, k,
                         bit has_exp = 0, vec_result_t exp = '0);
    vec_row_t row;
    row.op = op;
    row.a = '{a0, a1, a2};
    row.b = '{b0, b1, b2};
    row.k = k;
    row.has_exp = has_exp;
    row.exp = exp;
    directed.push_back(row);
  endtask

  task automatic build_table();
    // Saturating add and subtract at both extremes
    add_row(v3alu_pkg::CMD_ADD, MAX_POS, MAX_NEG, 0, 1, -1, 0, 0, 1,
            vres(MAX_POS, MAX_NEG, 0, 0, v3alu_pkg::ST_SAT));
    add_row(v3alu_pkg::CMD_SUB, MAX_NEG, MAX_POS, ONE, 1, -1, ONE, 0, 1,
            vres(MAX_NEG, MAX_POS, 0, 0, v3alu_pkg::ST_SAT));
    add_row(v3alu_pkg::CMD_ADD, ONE, 2 * ONE, -ONE, ONE, ONE, ONE, 0, 1,
            vres(2 * ONE, 3 * ONE, 0, 0, v3alu_pkg::ST_OK));
    // Divide by zero
    add_row(v3alu_pkg::CMD_DIV, ONE, MAX_NEG, MAX_POS, 0, 0, 0, 0, 1,
            vres(0, 0, 0, 0, v3alu_pkg::ST_DIVZERO));
    // Normalize the zero vector returns it
    add_row(v3alu_pkg::CMD_NORM, 0, 0, 0, 5, 6, 7, 9, 1,
            vres(0, 0, 0, 0, v3alu_pkg::ST_OK));
    // Magnitude too large for 32 bits
    add_row(v3alu_pkg::CMD_MAG, MAX_NEG, MAX_NEG, MAX_NEG, 0, 0, 0, 0, 1,
            vres(0, 0, 0, MAX_POS, v3alu_pkg::ST_SAT));
    add_row(v3alu_pkg::CMD_MAG, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 1,
            vres(0, 0, 0, 5 * ONE, v3alu_pkg::ST_OK));
    add_row(v3alu_pkg::CMD_SCALE, ONE, -ONE, MAX_POS, 0, 0, 0, ONE, 1,
            vres(ONE, -ONE, MAX_POS, 0, v3alu_pkg::ST_OK));
    // Rest checked against the predictor
    add_row(v3alu_pkg::CMD_SCALE, MAX_NEG, MAX_POS, 1, 0, 0, 0, MAX_NEG);
    add_row(v3alu_pkg::CMD_SCALE, 32'h0000_8000, 32'hFFFF_8000, 3, 0, 0, 0, 1);
    add_row(v3alu_pkg::CMD_DIV, MAX_NEG, MAX_POS, 1, 0, 0, 0, 1);
    add_row(v3alu_pkg::CMD_DIV, 3, -3, ONE, 0, 0, 0, -2 * ONE);
    add_row(v3alu_pkg::CMD_DIV, MAX_NEG, 7, -7, 0, 0, 0, MAX_NEG);
    add_row(v3alu_pkg::CMD_DOT, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, 0);
    add_row(v3alu_pkg::CMD_DOT, MAX_POS, 1, -1, MAX_NEG, 32'h8000, 32'h8000, 0);
    add_row(v3alu_pkg::CMD_CROSS, ONE, 0, 0, 0, ONE, 0, 0);
    add_row(v3alu_pkg::CMD_CROSS, MAX_NEG, MAX_POS, MAX_NEG, MAX_POS, MAX_NEG, MAX_NEG, 0);
    add_row(v3alu_pkg::CMD_NORM, 1, 0, 0, 0, 0, 0, 0);
    add_row(v3alu_pkg::CMD_NORM, MAX_NEG, MAX_NEG, MAX_NEG, 0, 0, 0, 0);
    add_row(v3alu_pkg::CMD_NORM, 3 * ONE, -4 * ONE, 0, 0, 0, 0, 0);
    add_row(v3alu_pkg::CMD_MAG, 1, 1, 1, 0, 0, 0, 0);
    add_row(v3alu_pkg::CMD_SUB, 32'hFFFF_FFFF, 0, MAX_POS, MAX_POS, MAX_NEG, MAX_NEG,
            MAX_POS);
  endtask

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_value(int size_class);
    logic [31:0] v;
    case (size_class)
      0: v = $urandom;
      1: v = $urandom_range(0, 3) == 0 ? MAX_POS : ($urandom_range(0, 1) ? MAX_NEG : 0);
      2: v = $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;     // everyday geometry
      default: v = $signed($urandom_range(0, 64)) - 32;         // tiny values
    endcase
    return v;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic offer_item(v3alu_pkg::cmd_t op, logic [31:0] a [3], logic [31:0] b [3],
                            logic [31:0] k, bit has_exp, vec_result_t exp);
    while (!quiet_phase && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    ax <= a[0]; ay <= a[1]; az <= a[2];
    bx <= b[0]; by <= b[1]; bz <= b[2];
    scale <= k;
    pending_results.push_back(has_exp ? exp : predict_vec_op(op, a, b, k));
    op_seen[op]++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic drive_random(int count);
    logic [31:0] a [3], b [3], k;
    v3alu_pkg::cmd_t op;
    int sc;
    for (int n = 0; n < count; n++) begin
      op = v3alu_pkg::cmd_t'($urandom_range(0, 7));
      sc = $urandom_range(0, 9) < 5 ? 2 : $urandom_range(0, 3);
      for (int i = 0; i < 3; i++) begin
        a[i] = pick_value(sc);
        b[i] = pick_value($urandom_range(0, 1) ? sc : $urandom_range(0, 3));
      end
      k = pick_value($urandom_range(0, 1) ? sc : $urandom_range(0, 3));
      if (op == v3alu_pkg::CMD_DIV && $urandom_range(0, 15) == 0) k = 0;
      if (op == v3alu_pkg::CMD_NORM && $urandom_range(0, 15) == 0) a = '{default: '0};
      offer_item(op, a, b, k, 0, '0);
    end
  endtask

  initial begin
    build_table();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i])
      offer_item(directed[i].op, directed[i].a, directed[i].b, directed[i].k,
                 directed[i].has_exp, directed[i].exp);
    drive_random(400);
    // Fill the pipeline against a stalled receiver
    hold_req = 1;
    drive_random(300);
    // Pause until the block has drained
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    // Run flat out with no idling
    quiet_phase = 1;
    drive_random(300);
    quiet_phase = 0;
    drive_random(N_RANDOM - 1000);
    in_valid <= 1'b0;
    send_done = 1;
  end

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // Hold off long enough for the pipeline to back up
        hold_req = 0;
        out_stall <= 1'b1;
        for (hold = 0; hold < 3 * LATENCY; hold++) @(posedge clk);
      end
      out_stall <= !quiet_phase && $urandom_range(0, 99) < 31;
    end
  end

  always @(posedge clk) begin
    vec_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = vres(rx, ry, rz, rscalar, status);
      n_recv++;
      if (got.st == v3alu_pkg::ST_SAT) sat_seen = 1;
      if (got.st == v3alu_pkg::ST_DIVZERO) dz_seen = 1;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp x=%h y=%h z=%h s=%h st=%0d got x=%h y=%h z=%h s=%h st=%0d",
                     n_recv, want.x, want.y, want.z, want.s, want.st,
                     got.x, got.y, got.z, got.s, got.st);
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int tail;
    @(negedge rst);
    tail = 0;
    while (!(send_done && pending_results.size() == 0 && tail > LATENCY + 20)) begin
      @(posedge clk);
      if (send_done && pending_results.size() == 0) tail++;
      if (idle_cycles > WATCHDOG) begin
        timed_out = 1;
        break;
      end
    end
    $display("sent %0d and checked %0d transactions over all eight opcodes", n_sent, n_recv);
    $display("saturation seen: %0d, divide by zero seen: %0d, mismatches: %0d",
             sat_seen, dz_seen, mismatches);
    if (timed_out) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("vector3_alu regression: fail");
    end else if (mismatches == 0 && pending_results.size() == 0) begin
      $display("vector3_alu regression: pass");
    end else begin
      $display("vector3_alu regression: fail");
    end
    $finish;
  end

endmodule
